/* rtl/ldcr_pkg.sv */
// Shared types and constants for the laserdisc command responder.
// Holds the beat structs, the parse-state and command-class enums and the sizing constants.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package ldcr_pkg;

    // Reply queue and frame digit store sizing.
    localparam int QUEUE_DEPTH = 5;
    localparam int FRAME_LEN   = 5;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int DIG_IDX_W   = $clog2(FRAME_LEN);
    localparam int DIG_PTR_W   = $clog2(FRAME_LEN + 1);

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Protocol bytes.
    localparam logic [7:0] ACK_BYTE     = 8'h0a;
    localparam logic [7:0] TEXT_END     = 8'h1a;
    localparam logic [7:0] CMD_INQUIRY  = 8'h60;
    localparam logic [7:0] CMD_TEXT     = 8'h80;
    localparam logic [7:0] CMD_CLR_TEXT = 8'h56;
    localparam logic [7:0] DIGIT_LO     = 8'h30;
    localparam logic [7:0] DIGIT_HI     = 8'h39;
    localparam logic [7:0] TEXT_ARG_HI  = 8'h02;
    localparam logic [7:0] TEXT_ARG_X   = 8'h00;
    localparam logic [7:0] TEXT_ARG_STR = 8'h01;

    typedef enum logic [2:0] {
        PM_GET_CMD     = 3'd0,
        PM_TEXT_CMD    = 3'd1,
        PM_TEXT_X      = 3'd2,
        PM_TEXT_Y      = 3'd3,
        PM_TEXT_MODE   = 3'd4,
        PM_TEXT_STRING = 3'd5,
        PM_SET_WINDOW  = 3'd6
    } parse_mode_t;

    typedef enum logic [2:0] {
        CL_NONE      = 3'd0,
        CL_TICK      = 3'd1,
        CL_TEXT_ARG  = 3'd2,
        CL_DIGIT     = 3'd3,
        CL_INQUIRY   = 3'd4,
        CL_TEXT      = 3'd5,
        CL_ACK       = 3'd6,
        CL_ACK_CLEAR = 3'd7
    } cmd_class_t;

    typedef struct packed {
        logic       func;
        logic [7:0] cmd_byte;
    } req_t;

    typedef struct packed {
        logic       resp_valid;
        logic [7:0] resp_byte;
        logic       overflow;
    } rsp_t;

    // One classified beat as it travels from the front to the back part.
    typedef struct packed {
        cmd_class_t cls;
        logic [7:0] cmd_byte;
    } item_t;

endpackage

`default_nettype wire

/* rtl/ldcr_front.sv */
// Front part of the laserdisc command responder: accepts request beats and classifies them.
// Uses ldcr_pkg; feeds ldcr_fifo through one registered stage.
`default_nettype none

module ldcr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ldcr_pkg::req_t req,
    output logic                push,
    output ldcr_pkg::item_t     push_item,
    input  wire logic           fifo_full
);

    logic            valid_reg;
    logic            valid_next;
    ldcr_pkg::item_t item_reg;
    ldcr_pkg::item_t item_next;
    logic            accept;

    assign req_stall = valid_reg && fifo_full;
    assign accept    = req_valid && !req_stall;
    assign push      = valid_reg && !fifo_full;
    assign push_item = item_reg;

    // The class depends only on the func bit and the byte; parse state lives in the back part.
    always_comb
    begin
        item_next.cmd_byte = req.cmd_byte;
        if (req.func) begin
            item_next.cls = ldcr_pkg::CL_TICK;
        end else if (req.cmd_byte <= ldcr_pkg::TEXT_ARG_HI) begin
            item_next.cls = ldcr_pkg::CL_TEXT_ARG;
        end else if (req.cmd_byte >= ldcr_pkg::DIGIT_LO && req.cmd_byte <= ldcr_pkg::DIGIT_HI) begin
            item_next.cls = ldcr_pkg::CL_DIGIT;
        end else if (req.cmd_byte == ldcr_pkg::CMD_INQUIRY) begin
            item_next.cls = ldcr_pkg::CL_INQUIRY;
        end else if (req.cmd_byte == ldcr_pkg::CMD_TEXT) begin
            item_next.cls = ldcr_pkg::CL_TEXT;
        end else if (req.cmd_byte == ldcr_pkg::CMD_CLR_TEXT) begin
            item_next.cls = ldcr_pkg::CL_ACK_CLEAR;
        end else if (req.cmd_byte inside {8'h24, 8'h26, 8'h27, 8'h3a, 8'h3f, 8'h40, 8'h43,
                                          8'h46, 8'h47, 8'h48, 8'h49, 8'h4f}) begin
            item_next.cls = ldcr_pkg::CL_ACK;
        end else begin
            item_next.cls = ldcr_pkg::CL_NONE;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ldcr_fifo.sv */
// Short queue of classified beats between the front and back parts.
// Uses ldcr_pkg for the item type and depth; register-based storage.
`default_nettype none

module ldcr_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ldcr_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output ldcr_pkg::item_t      pop_item,
    output logic                 empty
);

    ldcr_pkg::item_t                 store_reg [ldcr_pkg::FIFO_DEPTH];
    logic [ldcr_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [ldcr_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [ldcr_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [ldcr_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [ldcr_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [ldcr_pkg::FIFO_CNT_W-1:0] count_next;

    localparam logic [ldcr_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        ldcr_pkg::FIFO_PTR_W'(ldcr_pkg::FIFO_DEPTH - 1);

    assign full     = (count_reg == ldcr_pkg::FIFO_CNT_W'(ldcr_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/ldcr_back.sv */
// Back part of the laserdisc command responder: parse state, frame digits and reply queue.
// Uses ldcr_pkg; pops classified beats from ldcr_fifo and drives the registered response.
`default_nettype none

module ldcr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fifo_empty,
    input  wire ldcr_pkg::item_t pop_item,
    output logic                 pop,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output ldcr_pkg::rsp_t       rsp
);

    ldcr_pkg::parse_mode_t          mode_reg;
    ldcr_pkg::parse_mode_t          mode_next;
    logic [7:0]                     digits_reg [ldcr_pkg::FRAME_LEN];
    logic [7:0]                     digits_next [ldcr_pkg::FRAME_LEN];
    logic [ldcr_pkg::DIG_PTR_W-1:0] dptr_reg;
    logic [ldcr_pkg::DIG_PTR_W-1:0] dptr_next;
    logic [7:0]                     queue_reg [ldcr_pkg::QUEUE_DEPTH];
    logic [7:0]                     queue_next [ldcr_pkg::QUEUE_DEPTH];
    logic [ldcr_pkg::Q_CNT_W-1:0]   count_reg;
    logic [ldcr_pkg::Q_CNT_W-1:0]   count_next;
    logic [ldcr_pkg::Q_IDX_W-1:0]   sent_reg;
    logic [ldcr_pkg::Q_IDX_W-1:0]   sent_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    ldcr_pkg::rsp_t                 rsp_reg;
    ldcr_pkg::rsp_t                 rsp_next;
    logic                           out_ready;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign pop       = !fifo_empty && out_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [ldcr_pkg::Q_CNT_W-1:0]   sent_ext;
        logic [ldcr_pkg::Q_CNT_W-1:0]   sent_inc;
        logic [ldcr_pkg::Q_CNT_W:0]     bulk_sum;
        logic [ldcr_pkg::Q_CNT_W-1:0]   off;
        logic [ldcr_pkg::DIG_PTR_W-1:0] ptr_eff;
        logic                           do_cmd;

        mode_next      = mode_reg;
        digits_next    = digits_reg;
        dptr_next      = dptr_reg;
        queue_next     = queue_reg;
        count_next     = count_reg;
        sent_next      = sent_reg;
        rsp_next       = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        sent_ext       = ldcr_pkg::Q_CNT_W'(sent_reg);
        sent_inc       = sent_ext + 1'b1;
        bulk_sum       = {1'b0, count_reg} + (ldcr_pkg::Q_CNT_W + 1)'(ldcr_pkg::FRAME_LEN);
        ptr_eff        = (dptr_reg >= ldcr_pkg::DIG_PTR_W'(ldcr_pkg::FRAME_LEN)) ? '0 : dptr_reg;
        off            = '0;
        do_cmd         = 1'b0;

        if (pop) begin
            rsp_valid_next = 1'b1;
            if (pop_item.cls == ldcr_pkg::CL_TICK) begin
                // Send one queued byte; the queue resets once fully drained.
                if (sent_ext < count_reg) begin
                    rsp_next.resp_valid = 1'b1;
                    rsp_next.resp_byte  = queue_reg[sent_reg];
                    if (sent_inc >= count_reg) begin
                        sent_next  = '0;
                        count_next = '0;
                    end else begin
                        sent_next = sent_inc[ldcr_pkg::Q_IDX_W-1:0];
                    end
                end
            end else begin
                case (mode_reg)
                    ldcr_pkg::PM_TEXT_X:      mode_next = ldcr_pkg::PM_TEXT_Y;
                    ldcr_pkg::PM_TEXT_Y:      mode_next = ldcr_pkg::PM_TEXT_MODE;
                    ldcr_pkg::PM_TEXT_MODE:   mode_next = ldcr_pkg::PM_GET_CMD;
                    ldcr_pkg::PM_SET_WINDOW:  mode_next = ldcr_pkg::PM_GET_CMD;
                    ldcr_pkg::PM_TEXT_STRING:
                    begin
                        if (pop_item.cmd_byte == ldcr_pkg::TEXT_END) begin
                            mode_next = ldcr_pkg::PM_GET_CMD;
                        end
                    end
                    ldcr_pkg::PM_GET_CMD:     do_cmd = 1'b1;
                    ldcr_pkg::PM_TEXT_CMD:    do_cmd = 1'b1;
                    default:                  mode_next = ldcr_pkg::PM_GET_CMD;
                endcase

                if (do_cmd) begin
                    case (pop_item.cls)
                        ldcr_pkg::CL_TEXT_ARG:
                        begin
                            if (mode_reg == ldcr_pkg::PM_TEXT_CMD) begin
                                if (pop_item.cmd_byte == ldcr_pkg::TEXT_ARG_X) begin
                                    mode_next = ldcr_pkg::PM_TEXT_X;
                                end else if (pop_item.cmd_byte == ldcr_pkg::TEXT_ARG_STR) begin
                                    mode_next = ldcr_pkg::PM_TEXT_STRING;
                                end else begin
                                    mode_next = ldcr_pkg::PM_SET_WINDOW;
                                end
                            end
                        end
                        ldcr_pkg::CL_DIGIT:
                        begin
                            digits_next[ptr_eff[ldcr_pkg::DIG_IDX_W-1:0]] = pop_item.cmd_byte;
                            dptr_next = ptr_eff + 1'b1;
                            if (count_reg < ldcr_pkg::Q_CNT_W'(ldcr_pkg::QUEUE_DEPTH)) begin
                                queue_next[count_reg[ldcr_pkg::Q_IDX_W-1:0]] = ldcr_pkg::ACK_BYTE;
                                count_next = count_reg + 1'b1;
                            end else begin
                                rsp_next.overflow = 1'b1;
                            end
                        end
                        ldcr_pkg::CL_INQUIRY:
                        begin
                            // All stored digits go in at once, as many as fit.
                            for (int j = 0; j < ldcr_pkg::QUEUE_DEPTH; j++) begin
                                off = ldcr_pkg::Q_CNT_W'(j) - count_reg;
                                if (ldcr_pkg::Q_CNT_W'(j) >= count_reg &&
                                    off < ldcr_pkg::Q_CNT_W'(ldcr_pkg::FRAME_LEN)) begin
                                    queue_next[j] = digits_reg[off[ldcr_pkg::DIG_IDX_W-1:0]];
                                end
                            end
                            if (bulk_sum > (ldcr_pkg::Q_CNT_W + 1)'(ldcr_pkg::QUEUE_DEPTH)) begin
                                count_next        = ldcr_pkg::Q_CNT_W'(ldcr_pkg::QUEUE_DEPTH);
                                rsp_next.overflow = 1'b1;
                            end else begin
                                count_next = bulk_sum[ldcr_pkg::Q_CNT_W-1:0];
                            end
                        end
                        ldcr_pkg::CL_TEXT:
                        begin
                            mode_next = ldcr_pkg::PM_TEXT_CMD;
                        end
                        ldcr_pkg::CL_ACK,
                        ldcr_pkg::CL_ACK_CLEAR:
                        begin
                            if (pop_item.cls == ldcr_pkg::CL_ACK_CLEAR) begin
                                mode_next = ldcr_pkg::PM_GET_CMD;
                            end
                            if (count_reg < ldcr_pkg::Q_CNT_W'(ldcr_pkg::QUEUE_DEPTH)) begin
                                queue_next[count_reg[ldcr_pkg::Q_IDX_W-1:0]] = ldcr_pkg::ACK_BYTE;
                                count_next = count_reg + 1'b1;
                            end else begin
                                rsp_next.overflow = 1'b1;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= ldcr_pkg::PM_GET_CMD;
            dptr_reg      <= '0;
            count_reg     <= '0;
            sent_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ldcr_pkg::FRAME_LEN; i++) begin
                digits_reg[i] <= '0;
            end
        end else begin
            mode_reg      <= mode_next;
            dptr_reg      <= dptr_next;
            count_reg     <= count_next;
            sent_reg      <= sent_next;
            rsp_valid_reg <= rsp_valid_next;
            digits_reg    <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
        if (pop) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/laserdisc_command_responder.sv */
// Top level of the laserdisc command responder.
// Depends on ldcr_pkg, ldcr_front, ldcr_fifo and ldcr_back.
`default_nettype none

// The responder takes one request beat per clock cycle while req_stall is
// low, either a host command byte (func = 0) or a response tick (func = 1),
// and returns exactly one response beat for each, in order. A tick sends
// the next queued reply byte with resp_valid set, or an all-zero beat when
// nothing is queued; a command beat carries resp_valid = 0 and raises
// overflow when the reply queue was full and a reply byte had to be dropped.
// Sustained throughput is one beat per cycle in both directions when
// nothing stalls. A beat passes from request to response through the
// classifying front register, the beat queue and the response register,
// where the back part updates the parse state, frame digits and reply
// queue in a single step. The beat queue holds four classified beats, so
// the request side keeps flowing while the response side is stalled, until
// it is full. No clearing pass is needed after reset; requests go in at once.
module laserdisc_command_responder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ldcr_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ldcr_pkg::rsp_t      rsp
);

    // Classified beats travelling from the front part into the queue.
    logic            push;
    ldcr_pkg::item_t push_item;
    logic            fifo_full;

    // Classified beats leaving the queue for the back part.
    logic            pop;
    ldcr_pkg::item_t pop_item;
    logic            fifo_empty;

    // The front part decodes each byte into a command class without looking
    // at any parse state, so it never waits on the back part's results.
    ldcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    ldcr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    // The back part owns all state that the replies depend on and retires
    // one beat per cycle whenever its response register can take a result.
    ldcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_item   (pop_item),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

/* rtl/ldcr_checker.sv */
// Port-level checks for the laserdisc command responder, attached by bind.
// Depends on ldcr_pkg and laserdisc_command_responder.
`default_nettype none

module ldcr_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire ldcr_pkg::rsp_t rsp
);

    // A stalled response beat stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // A beat that sends nothing carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.resp_valid |-> rsp.resp_byte == 8'h00)
        else $error("response byte not zero without a sent byte");

    // Only command beats can drop replies, and those never send a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.resp_valid |-> !rsp.overflow)
        else $error("overflow flagged on a sending tick");

    // Right after reset nothing is pending and requests are taken at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid && !req_stall)
        else $error("block not idle right after reset");

    // Handshake outputs are always known, and so is every offered response beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({req_stall, rsp_valid}) && (!rsp_valid || !$isunknown(rsp)))
        else $error("unknown bits on the handshake or the response beat");

endmodule

bind laserdisc_command_responder ldcr_checker u_ldcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

/* tb/sv/laserdisc_command_responder_test.sv */
// Self-checking testbench for the laserdisc command responder.
// Drives command bytes and response ticks, predicts each response beat and checks it.
// Depends on ldcr_pkg and the laserdisc_command_responder RTL.
module laserdisc_command_responder_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Command bytes that queue an acknowledge when seen in a command state.
    localparam logic [7:0] ACK_CMDS [13] = '{
        8'h24, 8'h26, 8'h27, 8'h3a, 8'h3f, 8'h40, 8'h43,
        8'h46, 8'h47, 8'h48, 8'h49, 8'h4f, 8'h56
    };
    // A byte that no parse state gives any meaning to.
    localparam logic [7:0] BYTE_UNLISTED = 8'hff;
    localparam int PHASE_ITEMS = 600;

    // Tracks the parse state, the frame digits and the reply queue of the
    // player, and keeps one expected response beat per accepted request beat.
    class responder_model;
        ldcr_pkg::parse_mode_t mode;
        logic [7:0] digits [ldcr_pkg::FRAME_LEN];
        int unsigned digit_ptr;
        logic [7:0] replies [ldcr_pkg::QUEUE_DEPTH];
        int unsigned reply_count;
        int unsigned reply_sent;
        ldcr_pkg::rsp_t expected_q [$];
        int errors;

        function new();
            mode = ldcr_pkg::PM_GET_CMD;
            foreach (digits[i]) digits[i] = '0;
            foreach (replies[i]) replies[i] = '0;
            digit_ptr = 0;
            reply_count = 0;
            reply_sent = 0;
            errors = 0;
        endfunction

        // Returns 1 when the byte fit into the reply queue.
        function bit push_reply(logic [7:0] b);
            if (reply_count >= ldcr_pkg::QUEUE_DEPTH) return 1'b0;
            replies[ldcr_pkg::Q_IDX_W'(reply_count)] = b;
            reply_count++;
            return 1'b1;
        endfunction

        function void note_request(ldcr_pkg::req_t r);
            ldcr_pkg::rsp_t e;
            logic [7:0] c;
            bit listed;
            e = '0;
            c = r.cmd_byte;
            if (r.func) begin
                if (reply_sent < reply_count) begin
                    e.resp_valid = 1'b1;
                    e.resp_byte = replies[ldcr_pkg::Q_IDX_W'(reply_sent)];
                    reply_sent++;
                    if (reply_sent >= reply_count) begin
                        reply_sent = 0;
                        reply_count = 0;
                    end
                end
            end else begin
                case (mode)
                    ldcr_pkg::PM_TEXT_X: mode = ldcr_pkg::PM_TEXT_Y;
                    ldcr_pkg::PM_TEXT_Y: mode = ldcr_pkg::PM_TEXT_MODE;
                    ldcr_pkg::PM_TEXT_MODE, ldcr_pkg::PM_SET_WINDOW:
                        mode = ldcr_pkg::PM_GET_CMD;
                    ldcr_pkg::PM_TEXT_STRING:
                        if (c == ldcr_pkg::TEXT_END) mode = ldcr_pkg::PM_GET_CMD;
                    ldcr_pkg::PM_GET_CMD, ldcr_pkg::PM_TEXT_CMD: begin
                        listed = 1'b0;
                        foreach (ACK_CMDS[i]) if (ACK_CMDS[i] == c) listed = 1'b1;
                        if (c <= ldcr_pkg::TEXT_ARG_HI) begin
                            // Text arguments only mean something after the text command.
                            if (mode == ldcr_pkg::PM_TEXT_CMD) begin
                                if (c == ldcr_pkg::TEXT_ARG_X) mode = ldcr_pkg::PM_TEXT_X;
                                else if (c == ldcr_pkg::TEXT_ARG_STR)
                                    mode = ldcr_pkg::PM_TEXT_STRING;
                                else mode = ldcr_pkg::PM_SET_WINDOW;
                            end
                        end else if (c >= ldcr_pkg::DIGIT_LO && c <= ldcr_pkg::DIGIT_HI) begin
                            if (digit_ptr >= ldcr_pkg::FRAME_LEN) digit_ptr = 0;
                            digits[ldcr_pkg::DIG_IDX_W'(digit_ptr)] = c;
                            digit_ptr++;
                            e.overflow = !push_reply(ldcr_pkg::ACK_BYTE);
                        end else if (c == ldcr_pkg::CMD_INQUIRY) begin
                            foreach (digits[i]) if (!push_reply(digits[i])) e.overflow = 1'b1;
                        end else if (c == ldcr_pkg::CMD_TEXT) begin
                            mode = ldcr_pkg::PM_TEXT_CMD;
                        end else if (listed) begin
                            if (c == ldcr_pkg::CMD_CLR_TEXT) mode = ldcr_pkg::PM_GET_CMD;
                            e.overflow = !push_reply(ldcr_pkg::ACK_BYTE);
                        end
                    end
                    default: mode = ldcr_pkg::PM_GET_CMD;
                endcase
            end
            expected_q.push_back(e);
        endfunction

        function void check_response(ldcr_pkg::rsp_t got);
            ldcr_pkg::rsp_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: response beat with nothing outstanding: expected none, got %p",
                         $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.resp_valid !== e.resp_valid) begin
                $display("%0t: resp_valid expected %0b got %0b", $time, e.resp_valid,
                         got.resp_valid);
                errors++;
            end
            if (got.resp_byte !== e.resp_byte) begin
                $display("%0t: resp_byte expected %02h got %02h", $time, e.resp_byte,
                         got.resp_byte);
                errors++;
            end
            if (got.overflow !== e.overflow) begin
                $display("%0t: overflow expected %0b got %0b", $time, e.overflow,
                         got.overflow);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ldcr_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ldcr_pkg::rsp_t rsp;

    responder_model model = new();

    // Idle rates in percent; the phases of the run change them.
    int send_idle_pct = 32;
    int recv_idle_pct = 86;
    // Beats that exercise the parser or the queue; plain noise is not counted.
    int useful_items = 0;

    laserdisc_command_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The response side decides at each falling edge whether to stall the
    // next cycle. The stall is held through reset too, which does no harm.
    always @(negedge clk) begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Every accepted response beat is checked against the oldest prediction.
    // Outputs are sampled at the rising edge, before the block updates them.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) model.check_response(rsp);
    end

    // Presents one request beat. The task is entered at a falling edge and
    // returns at the falling edge after the beat was accepted, so valid is
    // assigned at most once per time step and stays high between back-to-back
    // beats. Random idle cycles go in front of the beat.
    task automatic send_request(ldcr_pkg::req_t r, bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        model.note_request(r);
        if (counted) useful_items++;
        @(negedge clk);
    endtask

    task automatic send_cmd(logic [7:0] c);
        send_request('{func: 1'b0, cmd_byte: c}, 1'b1);
    endtask

    // The byte of a tick is ignored by the block, so it carries random bits.
    task automatic send_tick();
        send_request('{func: 1'b1, cmd_byte: 8'($urandom_range(255))}, 1'b1);
    endtask

    // One random sequence. Most are well-formed: digit runs, inquiries,
    // acknowledged commands, complete text commands and runs of ticks that
    // drain the reply queue. A small share is raw noise that may leave the
    // parser in any state.
    task automatic random_sequence();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 18) begin
            repeat ($urandom_range(1, 6))
                send_cmd(ldcr_pkg::DIGIT_LO + 8'($urandom_range(9)));
        end else if (pick < 28) begin
            send_cmd(ldcr_pkg::CMD_INQUIRY);
        end else if (pick < 43) begin
            send_cmd(ACK_CMDS[4'($urandom_range(12))]);
        end else if (pick < 60) begin
            send_cmd(ldcr_pkg::CMD_TEXT);
            case ($urandom_range(4))
                0: begin
                    // Position and mode bytes take any value.
                    send_cmd(ldcr_pkg::TEXT_ARG_X);
                    repeat (3) send_cmd(8'($urandom_range(255)));
                end
                1: begin
                    send_cmd(ldcr_pkg::TEXT_ARG_STR);
                    repeat ($urandom_range(0, 6)) begin
                        do b = 8'($urandom_range(255)); while (b == ldcr_pkg::TEXT_END);
                        send_cmd(b);
                    end
                    send_cmd(ldcr_pkg::TEXT_END);
                end
                2: begin
                    send_cmd(ldcr_pkg::TEXT_ARG_HI);
                    send_cmd(8'($urandom_range(255)));
                end
                3: begin
                    // An ordinary command in the text-command state leaves
                    // the parser there for the next sequence, unless it is clear text.
                    send_cmd(ACK_CMDS[4'($urandom_range(12))]);
                end
                default: send_cmd(ldcr_pkg::CMD_CLR_TEXT);
            endcase
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 7)) send_tick();
        end else begin
            send_request(ldcr_pkg::req_t'(9'($urandom_range(511))), 1'b0);
        end
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A tick on an empty queue sends nothing, and the text
        // argument codes are ignored outside the text command.
        send_tick();
        send_cmd(ldcr_pkg::TEXT_ARG_X);
        send_cmd(ldcr_pkg::TEXT_ARG_STR);
        send_cmd(ldcr_pkg::TEXT_ARG_HI);
        // Six digits: five acknowledges fill the queue, the sixth is dropped
        // and its digit wraps around to the first slot of the frame store.
        send_cmd(ldcr_pkg::DIGIT_HI);
        send_cmd(ldcr_pkg::DIGIT_LO);
        send_cmd(ldcr_pkg::DIGIT_LO + 8'd3);
        send_cmd(ldcr_pkg::DIGIT_LO + 8'd5);
        send_cmd(ldcr_pkg::DIGIT_LO + 8'd7);
        send_cmd(ldcr_pkg::DIGIT_LO + 8'd1);
        // An inquiry into a full queue drops all five digits.
        send_cmd(ldcr_pkg::CMD_INQUIRY);
        repeat (5) send_tick();
        // This inquiry fills the queue again; later ticks read it out.
        send_cmd(ldcr_pkg::CMD_INQUIRY);
        send_cmd(BYTE_UNLISTED);
        // Text command with an acknowledged command inside it, then the
        // position bytes at their extremes and a mode byte.
        send_cmd(ldcr_pkg::CMD_TEXT);
        send_cmd(ACK_CMDS[0]);
        send_cmd(ldcr_pkg::TEXT_ARG_X);
        send_cmd(BYTE_UNLISTED);
        send_cmd(8'h00);
        send_cmd(ldcr_pkg::TEXT_END);
        // Empty string, set window, and clear text leaving the text command.
        send_cmd(ldcr_pkg::CMD_TEXT);
        send_cmd(ldcr_pkg::TEXT_ARG_STR);
        send_cmd(ldcr_pkg::TEXT_END);
        send_cmd(ldcr_pkg::CMD_TEXT);
        send_cmd(ldcr_pkg::TEXT_ARG_HI);
        send_cmd(ldcr_pkg::CMD_INQUIRY);
        send_cmd(ldcr_pkg::CMD_TEXT);
        send_cmd(ldcr_pkg::CMD_CLR_TEXT);

        // Random part in three phases: a fast sender against a slow
        // receiver and the reverse, then full speed on both sides.
        useful_items = 0;
        while (useful_items < PHASE_ITEMS) random_sequence();
        send_idle_pct = 86;
        recv_idle_pct = 32;
        while (useful_items < 2 * PHASE_ITEMS) random_sequence();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (useful_items < 3 * PHASE_ITEMS) random_sequence();
        req_valid <= 1'b0;

        // Wait for every predicted beat, then keep the clock running so that a
        // stray extra beat would still be caught.
        while (model.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (model.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // The slowest correct run is a few hundred microseconds; this allows
    // many times that before giving up.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
